// ===== hdl/mdf_pkg.sv =====
// Package for the message deframer: register map, result codes, mode codes,
// delimiter characters and the structs shared between the deframer modules.
// No dependencies.
package mdf_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Frame modes
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_LEN   = 2'd1;
    localparam logic [1:0] MODE_DELIM = 2'd2;

    // Register map, selected by paddr[2]
    localparam int unsigned ADDR_W       = 3;
    localparam logic        REG_MODE     = 1'b0;
    localparam logic        REG_MAX_LEN  = 1'b1;

    // Register reset values
    localparam logic [1:0]  MODE_RST     = MODE_RAW;
    localparam logic [31:0] MAX_LEN_RST  = 32'd65536;

    // Delimiter characters and length
    localparam logic [7:0]  CR_CHAR      = 8'h0D;
    localparam logic [7:0]  LF_CHAR      = 8'h0A;
    localparam logic [33:0] DELIM_LEN    = 34'd4;

    // Configuration seen by the engine
    typedef struct packed {
        logic [1:0]  frame_mode;
        logic [31:0] max_frame_len;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } result_t;

endpackage

// ===== hdl/mdf_if.sv =====
// Valid/ready channel interfaces for the message deframer: received bytes in,
// result items out. Depends on nothing.
interface mdf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface mdf_msg_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ===== hdl/mdf_cfg_regs.sv =====
// APB-style configuration registers of the message deframer (frame mode and
// maximum frame length). Depends on mdf_pkg.
module mdf_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output mdf_pkg::cfg_t               cfg
);

    logic [1:0]  frame_mode_reg;
    logic [31:0] max_frame_len_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes, decoded on the word address bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg    <= mdf_pkg::MODE_RST;
            max_frame_len_reg <= mdf_pkg::MAX_LEN_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                mdf_pkg::REG_MODE:    frame_mode_reg    <= pwdata[1:0];
                mdf_pkg::REG_MAX_LEN: max_frame_len_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (paddr[2])
            mdf_pkg::REG_MODE:    prdata = {30'd0, frame_mode_reg};
            mdf_pkg::REG_MAX_LEN: prdata = max_frame_len_reg;
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.frame_mode    = frame_mode_reg;
    assign cfg.max_frame_len = max_frame_len_reg;

endmodule

// ===== hdl/mdf_engine.sv =====
// Framing state and next-state logic of the message deframer: one byte is
// processed per enabled cycle and gives zero or one result. Depends on mdf_pkg.
module mdf_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          in_byte,
    input  logic                chunk_end,
    input  mdf_pkg::cfg_t       cfg,
    output logic                res_valid,
    output mdf_pkg::result_t    res
);

    logic        in_payload_reg,   in_payload_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] bytes_left_reg,   bytes_left_next;
    logic [1:0]  delim_match_reg,  delim_match_next;
    logic [32:0] message_count_reg, message_count_next;
    logic        error_flag_reg,   error_flag_next;

    logic [32:0] cnt;
    logic [33:0] max_plus4;
    logic [31:0] acc;
    logic [31:0] bl_dec;
    logic [1:0]  m_next;
    logic        m_done;

    // Delimiter prefix tracking with fallback on CR
    always_comb
    begin
        m_next = 2'd0;
        m_done = 1'b0;
        case (delim_match_reg)
            2'd0: m_next = (in_byte == mdf_pkg::CR_CHAR) ? 2'd1 : 2'd0;
            2'd1:
            begin
                if (in_byte == mdf_pkg::LF_CHAR)
                    m_next = 2'd2;
                else
                    m_next = (in_byte == mdf_pkg::CR_CHAR) ? 2'd1 : 2'd0;
            end
            2'd2: m_next = (in_byte == mdf_pkg::CR_CHAR) ? 2'd3 : 2'd0;
            default:
            begin
                if (in_byte == mdf_pkg::LF_CHAR)
                    m_done = 1'b1;
                else
                    m_next = (in_byte == mdf_pkg::CR_CHAR) ? 2'd1 : 2'd0;
            end
        endcase
    end

    assign cnt       = message_count_reg + 33'd1;
    assign max_plus4 = {2'd0, cfg.max_frame_len} + mdf_pkg::DELIM_LEN;
    assign acc       = {length_accum_reg[23:0], in_byte};
    assign bl_dec    = bytes_left_reg - 32'd1;

    // Per-byte framing decision
    always_comb
    begin
        in_payload_next    = in_payload_reg;
        header_count_next  = header_count_reg;
        length_accum_next  = length_accum_reg;
        bytes_left_next    = bytes_left_reg;
        delim_match_next   = delim_match_reg;
        message_count_next = message_count_reg;
        error_flag_next    = error_flag_reg;
        res_valid          = 1'b0;
        res.kind           = mdf_pkg::KIND_BYTE;
        res.out_byte       = in_byte;
        res.last           = 1'b0;

        if (step_en && !error_flag_reg)
        begin
            unique case (cfg.frame_mode)
                mdf_pkg::MODE_RAW:
                begin
                    res_valid = 1'b1;
                    if (cnt > {1'b0, cfg.max_frame_len})
                    begin
                        res.kind        = mdf_pkg::KIND_ERROR;
                        error_flag_next = 1'b1;
                    end
                    else
                    begin
                        message_count_next = chunk_end ? 33'd0 : cnt;
                        res.last           = chunk_end;
                    end
                end
                mdf_pkg::MODE_LEN:
                begin
                    if (!in_payload_reg)
                    begin
                        // Header byte, big-endian length
                        length_accum_next = acc;
                        header_count_next = header_count_reg + 2'd1;
                        if (header_count_reg == 2'd3)
                        begin
                            if (acc > cfg.max_frame_len)
                            begin
                                res_valid       = 1'b1;
                                res.kind        = mdf_pkg::KIND_ERROR;
                                error_flag_next = 1'b1;
                            end
                            else if (acc == 32'd0)
                            begin
                                res_valid = 1'b1;
                                res.kind  = mdf_pkg::KIND_EMPTY;
                                res.last  = 1'b1;
                            end
                            else
                            begin
                                bytes_left_next   = acc;
                                length_accum_next = 32'd0;
                                in_payload_next   = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // Payload byte
                        res_valid       = 1'b1;
                        bytes_left_next = bl_dec;
                        if (bl_dec == 32'd0)
                        begin
                            in_payload_next   = 1'b0;
                            header_count_next = 2'd0;
                            length_accum_next = 32'd0;
                            res.last          = 1'b1;
                        end
                    end
                end
                mdf_pkg::MODE_DELIM:
                begin
                    res_valid = 1'b1;
                    if (m_done)
                    begin
                        // Payload is the count less the delimiter
                        if (({1'b0, cnt} < mdf_pkg::DELIM_LEN) || ({1'b0, cnt} > max_plus4))
                        begin
                            res.kind        = mdf_pkg::KIND_ERROR;
                            error_flag_next = 1'b1;
                        end
                        else
                        begin
                            message_count_next = 33'd0;
                            delim_match_next   = 2'd0;
                            res.last           = 1'b1;
                        end
                    end
                    else if ({1'b0, cnt} >= max_plus4)
                    begin
                        res.kind        = mdf_pkg::KIND_ERROR;
                        error_flag_next = 1'b1;
                    end
                    else
                    begin
                        message_count_next = cnt;
                        delim_match_next   = m_next;
                    end
                end
                default: ;
            endcase
        end

        // Error and empty results carry no byte
        if (res.kind != mdf_pkg::KIND_BYTE)
            res.out_byte = 8'd0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg    <= 1'b0;
            header_count_reg  <= 2'd0;
            length_accum_reg  <= 32'd0;
            bytes_left_reg    <= 32'd0;
            delim_match_reg   <= 2'd0;
            message_count_reg <= 33'd0;
            error_flag_reg    <= 1'b0;
        end
        else
        begin
            in_payload_reg    <= in_payload_next;
            header_count_reg  <= header_count_next;
            length_accum_reg  <= length_accum_next;
            bytes_left_reg    <= bytes_left_next;
            delim_match_reg   <= delim_match_next;
            message_count_reg <= message_count_next;
            error_flag_reg    <= error_flag_next;
        end
    end

endmodule

// ===== hdl/message_deframer_core.sv =====
// Top level of the message deframer: input byte register, framing engine,
// result register and configuration port.
// Depends on mdf_pkg, mdf_if, mdf_cfg_regs and mdf_engine.
//
// Usage:
//   rx  - valid/ready channel of received bytes (in_byte, chunk_end), one
//         byte per transaction.
//   msg - valid/ready channel of results (kind, out_byte, last): message
//         bytes, empty-message marks and the frame error.
//   APB - frame_mode at 0x0, max_frame_len at 0x4; write only while idle.
// An accepted byte is loaded into the input register, its result into the
// result register, which presents it on msg. Throughput: one byte per cycle
// while msg is ready; header bytes (bar an empty or over-long length), bytes
// in the unused mode and bytes after an error give no result.
// Throughput is set by the single framing step between the two registers.
// When msg stalls, the result register holds; one more byte may wait in the
// input register and then rx.ready drops until the result is taken.
// Reset clears all framing state and the sticky error, and sets mode 0 with
// a maximum frame length of 65536 bytes.
module message_deframer_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    mdf_rx_if.sink                      rx,
    mdf_msg_if.source                   msg,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mdf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    mdf_pkg::cfg_t    cfg;
    mdf_pkg::result_t res;
    logic             res_valid;
    logic             advance;

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_ce_reg;
    logic             out_valid_reg;
    mdf_pkg::result_t out_reg;

    mdf_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Byte in the input register moves on when the result register is free
    assign advance  = s1_valid_reg && (!out_valid_reg || msg.ready);
    assign rx.ready = !s1_valid_reg || advance;

    mdf_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .in_byte   (s1_byte_reg),
        .chunk_end (s1_ce_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx.valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.in_byte;
            s1_ce_reg   <= rx.chunk_end;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (msg.ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_reg <= res;
    end

    assign msg.valid    = out_valid_reg;
    assign msg.kind     = out_reg.kind;
    assign msg.out_byte = out_reg.out_byte;
    assign msg.last     = out_reg.last;

endmodule

// ===== hdl/mdf_checker.sv =====
// Port-level checks for message_deframer_core and the bind that attaches
// them. Depends on mdf_pkg and message_deframer_core.
module mdf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic [1:0] msg_kind,
    input logic [7:0] msg_out_byte,
    input logic       msg_last,
    input logic       pready
);

    // A stalled result holds until taken
    a_msg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid && $stable(msg_kind)
            && $stable(msg_out_byte) && $stable(msg_last))
        else $error("msg result changed while stalled");

    // The error is sticky: nothing follows a delivered error
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && (msg_kind == mdf_pkg::KIND_ERROR) |=> !msg_valid)
        else $error("result after frame error");

    // Error results carry no byte and no end mark
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && (msg_kind == mdf_pkg::KIND_ERROR) |-> (msg_out_byte == 8'd0) && !msg_last)
        else $error("error result with data");

    // Empty messages are zero bytes with the end mark
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && (msg_kind == mdf_pkg::KIND_EMPTY) |-> (msg_out_byte == 8'd0) && msg_last)
        else $error("malformed empty message");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind message_deframer_core mdf_checker u_mdf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg.valid),
    .msg_ready    (msg.ready),
    .msg_kind     (msg.kind),
    .msg_out_byte (msg.out_byte),
    .msg_last     (msg.last),
    .pready       (pready)
);

// ===== dv/message_deframer_core_tb.sv =====
// Self-checking testbench for message_deframer_core: streams bytes in all frame modes,
// predicts every result item in a local model of the framing rules and compares it.
// Depends on mdf_pkg, mdf_if (mdf_rx_if, mdf_msg_if) and the deframer RTL.
module message_deframer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         DRAIN_LIMIT    = 20000;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         PRINT_LIMIT    = 100;

    // CR CR LF CR CR LF CR LF: exercises delimiter fallback, completes on the last byte
    localparam logic [7:0] FALLBACK_SEQ [8] = '{mdf_pkg::CR_CHAR, mdf_pkg::CR_CHAR,
                                                mdf_pkg::LF_CHAR, mdf_pkg::CR_CHAR,
                                                mdf_pkg::CR_CHAR, mdf_pkg::LF_CHAR,
                                                mdf_pkg::CR_CHAR, mdf_pkg::LF_CHAR};

    typedef struct packed {
        logic [7:0] data;
        logic       chunk_end;
    } rx_item_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [mdf_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    mdf_rx_if  rx_ch ();
    mdf_msg_if msg_ch ();

    message_deframer_core u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .msg     (msg_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Stimulus and expectations
    rx_item_t          pending_bytes [$];
    mdf_pkg::result_t  expected_results [$];

    // Idling control
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_requests = 0;
    int hold_grants   = 0;
    int hold_left;

    // Bookkeeping
    int    n_mismatches = 0;
    int    n_bytes_in   = 0;
    int    n_msg_bytes  = 0;
    int    n_empty      = 0;
    int    n_errors     = 0;
    int    n_last       = 0;
    int    quiet_cycles = 0;
    string fail_case    = "none";

    // Local copy of the configuration and the framing state
    logic [1:0]  cfg_mode    = mdf_pkg::MODE_RST;
    logic [31:0] cfg_max     = mdf_pkg::MAX_LEN_RST;
    logic        in_payload  = 1'b0;
    logic [1:0]  hdr_cnt     = 2'd0;
    logic [31:0] len_acc     = 32'd0;
    logic [31:0] bytes_left  = 32'd0;
    logic [1:0]  delim_m     = 2'd0;
    logic [63:0] msg_cnt     = 64'd0;
    logic        err_flag    = 1'b0;

    task automatic report_mismatch(input string what);
        n_mismatches++;
        if (n_mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Framing step for one accepted byte; queues the result it causes, if any
    task automatic deframe_byte(input logic [7:0] b, input logic ce);
        logic [63:0]      cnt;
        logic [2:0]       m;
        logic             hit;
        mdf_pkg::result_t r;
        hit = 1'b0;
        r   = '0;
        if (!err_flag) begin
            case (cfg_mode)
                mdf_pkg::MODE_RAW:
                begin
                    hit = 1'b1;
                    cnt = msg_cnt + 64'd1;
                    if (cnt > {32'd0, cfg_max})
                        r.kind = mdf_pkg::KIND_ERROR;
                    else
                    begin
                        msg_cnt    = ce ? 64'd0 : cnt;
                        r.kind     = mdf_pkg::KIND_BYTE;
                        r.out_byte = b;
                        r.last     = ce;
                    end
                end
                mdf_pkg::MODE_LEN:
                begin
                    if (!in_payload)
                    begin
                        len_acc = {len_acc[23:0], b};
                        hdr_cnt = hdr_cnt + 2'd1;
                        if (hdr_cnt == 2'd0)
                        begin
                            if (len_acc > cfg_max)
                            begin
                                hit    = 1'b1;
                                r.kind = mdf_pkg::KIND_ERROR;
                            end
                            else if (len_acc == 32'd0)
                            begin
                                hit    = 1'b1;
                                r.kind = mdf_pkg::KIND_EMPTY;
                                r.last = 1'b1;
                            end
                            else
                            begin
                                bytes_left = len_acc;
                                len_acc    = 32'd0;
                                in_payload = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        hit        = 1'b1;
                        bytes_left = bytes_left - 32'd1;
                        r.kind     = mdf_pkg::KIND_BYTE;
                        r.out_byte = b;
                        if (bytes_left == 32'd0)
                        begin
                            in_payload = 1'b0;
                            hdr_cnt    = 2'd0;
                            len_acc    = 32'd0;
                            r.last     = 1'b1;
                        end
                    end
                end
                mdf_pkg::MODE_DELIM:
                begin
                    hit = 1'b1;
                    cnt = msg_cnt + 64'd1;
                    // matched prefix of CR LF CR LF after this byte
                    case (delim_m)
                        2'd0:    m = (b == mdf_pkg::CR_CHAR) ? 3'd1 : 3'd0;
                        2'd1:    m = (b == mdf_pkg::LF_CHAR) ? 3'd2 :
                                     (b == mdf_pkg::CR_CHAR) ? 3'd1 : 3'd0;
                        2'd2:    m = (b == mdf_pkg::CR_CHAR) ? 3'd3 : 3'd0;
                        default: m = (b == mdf_pkg::LF_CHAR) ? 3'd4 :
                                     (b == mdf_pkg::CR_CHAR) ? 3'd1 : 3'd0;
                    endcase
                    if (m == 3'd4)
                    begin
                        // payload length wraps when the count was cleared under the match
                        if (cnt - 64'(mdf_pkg::DELIM_LEN) > {32'd0, cfg_max})
                            r.kind = mdf_pkg::KIND_ERROR;
                        else
                        begin
                            msg_cnt    = 64'd0;
                            delim_m    = 2'd0;
                            r.kind     = mdf_pkg::KIND_BYTE;
                            r.out_byte = b;
                            r.last     = 1'b1;
                        end
                    end
                    else if (cnt >= {32'd0, cfg_max} + 64'(mdf_pkg::DELIM_LEN))
                        r.kind = mdf_pkg::KIND_ERROR;
                    else
                    begin
                        msg_cnt    = cnt;
                        delim_m    = m[1:0];
                        r.kind     = mdf_pkg::KIND_BYTE;
                        r.out_byte = b;
                    end
                end
                default: ;  // unused mode swallows the byte
            endcase
        end
        if (hit)
        begin
            if (r.kind == mdf_pkg::KIND_ERROR)
                err_flag = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid     <= 1'b0;
            rx_ch.in_byte   <= 8'd0;
            rx_ch.chunk_end <= 1'b0;
        end
        else
        begin : drv_blk
            rx_item_t nxt;
            if (rx_ch.valid && rx_ch.ready)
            begin
                deframe_byte(rx_ch.in_byte, rx_ch.chunk_end);
                n_bytes_in++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    rx_ch.valid     <= 1'b1;
                    rx_ch.in_byte   <= nxt.data;
                    rx_ch.chunk_end <= nxt.chunk_end;
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_grants != hold_requests)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_grants <= hold_grants + 1;
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msg_ch.ready <= 1'b0;
        else
        begin : mon_blk
            mdf_pkg::result_t want;
            if (msg_ch.valid && msg_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind=%0d byte=%02h last=%0b",
                                              msg_ch.kind, msg_ch.out_byte, msg_ch.last));
                else
                begin
                    want = expected_results.pop_front();
                    if (msg_ch.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  msg_ch.kind, want.kind));
                    if (msg_ch.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  msg_ch.out_byte, want.out_byte));
                    if (msg_ch.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  msg_ch.last, want.last));
                end
                case (msg_ch.kind)
                    mdf_pkg::KIND_BYTE:  n_msg_bytes++;
                    mdf_pkg::KIND_EMPTY: n_empty++;
                    default:             n_errors++;
                endcase
                if (msg_ch.last === 1'b1)
                    n_last++;
            end
            msg_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (msg_ch.valid && msg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic push_item(input logic [7:0] b, input logic ce);
        rx_item_t it;
        it.data      = b;
        it.chunk_end = ce;
        pending_bytes.push_back(it);
    endtask

    // Big-endian length header
    task automatic push_hdr(input logic [31:0] len);
        for (int i = 3; i >= 0; i--)
            push_item(len[8*i +: 8], 1'b0);
    endtask

    task automatic push_raw_msg(input int len);
        for (int i = 1; i <= len; i++)
            push_item(8'($urandom_range(255)), i == len);
    endtask

    task automatic push_len_frame(input int len);
        push_hdr(32'(len));
        for (int i = 0; i < len; i++)
            push_item(8'($urandom_range(255)), 1'(($urandom_range(1))));
    endtask

    // Content rich in CR/LF, then a plain byte so the closing delimiter ends the message
    task automatic push_delim_msg(input int len);
        logic [7:0] b;
        int         r;
        for (int i = 0; i < len - 1; i++)
        begin
            r = $urandom_range(9);
            b = (r < 4) ? mdf_pkg::CR_CHAR :
                (r < 7) ? mdf_pkg::LF_CHAR : 8'($urandom_range(255));
            push_item(b, 1'($urandom_range(1)));
        end
        do
            b = 8'($urandom_range(255));
        while (b == mdf_pkg::CR_CHAR || b == mdf_pkg::LF_CHAR);
        push_item(b, 1'($urandom_range(1)));
        push_item(mdf_pkg::CR_CHAR, 1'b0);
        push_item(mdf_pkg::LF_CHAR, 1'b1);
        push_item(mdf_pkg::CR_CHAR, 1'b0);
        push_item(mdf_pkg::LF_CHAR, 1'b0);
    endtask

    // Wait until all bytes are in, all results checked and the pipeline is quiet
    task automatic drain();
        int waited;
        waited = 0;
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || rx_ch.valid);
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
            expected_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
        logic [31:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_sel == mdf_pkg::REG_MODE)
            cfg_mode = value[1:0];
        else
            cfg_max = value;
        want    = (reg_sel == mdf_pkg::REG_MODE) ? {30'd0, value[1:0]} : value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %08h, expected %08h",
                                      reg_sel, prdata, want));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random phase of well-formed traffic for the given mode
    task automatic random_phase(input int n_items, input logic [1:0] mode,
                                input logic [31:0] max_len);
        int cap;
        int made;
        int len;
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mode});
        cfg_write(mdf_pkg::REG_MAX_LEN, max_len);
        cap  = (max_len < 32'd30) ? int'(max_len) : 30;
        made = 0;
        while (made < n_items)
        begin
            case (mode)
                mdf_pkg::MODE_RAW:
                begin
                    len = $urandom_range(cap, 1);
                    push_raw_msg(len);
                    made += len;
                end
                mdf_pkg::MODE_LEN:
                begin
                    len = ($urandom_range(7) == 0) ? 0 : $urandom_range(cap, 1);
                    push_len_frame(len);
                    made += len + 4;
                end
                mdf_pkg::MODE_DELIM:
                begin
                    len = $urandom_range(cap, 1);
                    push_delim_msg(len);
                    made += len + 4;
                end
                default:
                begin
                    push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
                    made++;
                end
            endcase
        end
        drain();
    endtask

    initial
    begin : main_seq
        logic [1:0]  mode;
        logic [31:0] max_len;
        int          sel;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = 32'd0;
        rx_ch.valid     = 1'b0;
        rx_ch.in_byte   = 8'd0;
        rx_ch.chunk_end = 1'b0;
        msg_ch.ready    = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: one-byte length frame at the largest maximum
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_LEN});
        cfg_write(mdf_pkg::REG_MAX_LEN, 32'hFFFF_FFFF);
        push_hdr(32'd1);
        push_item(8'hAA, 1'b0);
        drain();

        // Delimiter with fallback, then a message left open
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_DELIM});
        foreach (FALLBACK_SEQ[i])
            push_item(FALLBACK_SEQ[i], 1'b0);
        push_item(8'h78, 1'b0);
        push_item(mdf_pkg::CR_CHAR, 1'b0);
        drain();

        // Mode changes mid-stream: half a header, finish the delimiter, finish the header
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_LEN});
        push_hdr(32'd0);
        void'(pending_bytes.pop_back());
        void'(pending_bytes.pop_back());
        drain();
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_DELIM});
        push_item(mdf_pkg::LF_CHAR, 1'b0);
        push_item(mdf_pkg::CR_CHAR, 1'b0);
        push_item(mdf_pkg::LF_CHAR, 1'b0);
        drain();
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_LEN});
        push_item(8'h00, 1'b0);
        push_item(8'h01, 1'b0);
        push_item(8'h7E, 1'b1);
        drain();

        // Unused mode value swallows bytes
        cfg_write(mdf_pkg::REG_MODE, {30'd0, MODE_UNUSED});
        push_item(8'h3C, 1'b1);
        drain();

        // Maximum of zero: bare delimiter and empty message still pass
        cfg_write(mdf_pkg::REG_MAX_LEN, 32'd0);
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_DELIM});
        push_item(mdf_pkg::CR_CHAR, 1'b0);
        push_item(mdf_pkg::LF_CHAR, 1'b0);
        push_item(mdf_pkg::CR_CHAR, 1'b0);
        push_item(mdf_pkg::LF_CHAR, 1'b0);
        drain();
        cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_LEN});
        push_hdr(32'd0);
        drain();

        // Random phases over modes, maxima and idling profiles
        for (int p = 0; p < 13; p++)
        begin
            case (p % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 55; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 55; end
                default: begin src_idle_pct = 13; snk_stall_pct = 13; end
            endcase
            case (p % 3)
                0:       mode = mdf_pkg::MODE_RAW;
                1:       mode = mdf_pkg::MODE_LEN;
                default: mode = mdf_pkg::MODE_DELIM;
            endcase
            case ($urandom_range(3))
                0:       max_len = $urandom_range(8, 1);
                1:       max_len = $urandom_range(300, 16);
                2:       max_len = mdf_pkg::MAX_LEN_RST;
                default: max_len = 32'hFFFF_FFFF;
            endcase
            // receiver holds off while the sender keeps pushing
            if (p == 4)
                hold_requests++;
            random_phase(100, mode, max_len);
        end
        random_phase(20, MODE_UNUSED, mdf_pkg::MAX_LEN_RST);

        // Final phase: force one frame error, then show it sticks
        src_idle_pct  = 13;
        snk_stall_pct = 13;
        sel = $urandom_range(3);
        case (sel)
            0:
            begin
                fail_case = "raw message over maximum";
                cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_RAW});
                cfg_write(mdf_pkg::REG_MAX_LEN, 32'd3);
                for (int i = 0; i < 4; i++)
                    push_item(8'($urandom_range(255)), 1'b0);
            end
            1:
            begin
                fail_case = "length header over maximum";
                cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_LEN});
                cfg_write(mdf_pkg::REG_MAX_LEN, 32'd10);
                push_hdr(32'd11);
            end
            2:
            begin
                fail_case = "delimiter completing after count cleared";
                cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_DELIM});
                cfg_write(mdf_pkg::REG_MAX_LEN, mdf_pkg::MAX_LEN_RST);
                push_item(mdf_pkg::CR_CHAR, 1'b0);
                push_item(mdf_pkg::LF_CHAR, 1'b0);
                push_item(mdf_pkg::CR_CHAR, 1'b0);
                drain();
                cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_RAW});
                push_item(8'h7A, 1'b1);
                drain();
                cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_DELIM});
                push_item(mdf_pkg::LF_CHAR, 1'b0);
            end
            default:
            begin
                fail_case = "no delimiter within maximum";
                cfg_write(mdf_pkg::REG_MODE, {30'd0, mdf_pkg::MODE_DELIM});
                cfg_write(mdf_pkg::REG_MAX_LEN, 32'd2);
                for (int i = 0; i < 6; i++)
                    push_item(8'h41 + 8'(i), 1'b0);
            end
        endcase
        for (int i = 0; i < 40; i++)
            push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        drain();

        $display("Run covered %0d input bytes over raw, length, delimiter and unused modes.",
                 n_bytes_in);
        $display("Checked %0d message bytes, %0d message ends, %0d empty, %0d error (%s).",
                 n_msg_bytes, n_last, n_empty, n_errors, fail_case);
        if (n_mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== message_deframer_core.f =====
hdl/mdf_pkg.sv
hdl/mdf_if.sv
hdl/mdf_cfg_regs.sv
hdl/mdf_engine.sv
hdl/message_deframer_core.sv
hdl/mdf_checker.sv
dv/message_deframer_core_tb.sv
